// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the decoder RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Implication within the same clock edge
`define HSD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsd assertion failed");
// Implication checked at the next clock edge
`define HSD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hsd assertion failed");
`else
`define HSD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define HSD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/hsd_pkg.sv =====
// Shared constants, types and bit-position functions of the SECDED block decoder.
// No dependencies.
package hsd_pkg;

  localparam int BlockBytes = 16;
  localparam int DataMax    = BlockBytes - 1;
  localparam int FirstSkip  = 4;
  localparam int SynW       = 7;
  localparam int CountW     = $clog2(BlockBytes);
  localparam int ByteW      = 8;
  localparam int LocW       = SynW;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_DOUBLE = 2'd1,
    STATUS_TRUNC  = 2'd2
  } status_t;

  // Command from the block control to the emitter
  typedef struct packed {
    logic              start;
    status_t           status;
    logic [CountW-1:0] n;
    logic              fix_en;
    logic [CountW-1:0] fix_idx;
    logic [ByteW-1:0]  fix_mask;
    logic              msg_end;
  } emit_cmd_t;

  // Hamming position of data bit j: start at 3, skip the powers of two
  function automatic logic [SynW-1:0] bit_pos(input logic [SynW-1:0] j);
    logic [SynW:0] p;
    p = {1'b0, j} + (SynW+1)'(3);
    for (int s = $clog2(FirstSkip); s < SynW; s++) begin
      if (p >= ((SynW+1)'(1) << s)) p = p + (SynW+1)'(1);
    end
    return p[SynW-1:0];
  endfunction

  // Index of the highest set bit
  function automatic logic [$clog2(SynW)-1:0] floor_log2(input logic [SynW-1:0] v);
    logic [$clog2(SynW)-1:0] r;
    r = '0;
    for (int i = 1; i < SynW; i++) begin
      if (v[i]) r = ($clog2(SynW))'(i);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/hsd_if.sv =====
// Valid/ready stream interfaces for the coded input and the decoded output.
// Depends on hsd_pkg.
interface hsd_in_if;
  logic                    valid;
  logic                    ready;
  logic [hsd_pkg::ByteW-1:0] code_byte;
  logic                    message_end;

  modport source (output valid, code_byte, message_end, input ready);
  modport sink   (input valid, code_byte, message_end, output ready);
endinterface

interface hsd_out_if;
  logic                      valid;
  logic                      ready;
  logic [hsd_pkg::ByteW-1:0] data_byte;
  hsd_pkg::status_t          status;
  logic                      run_last;
  logic                      message_last;

  modport source (output valid, data_byte, status, run_last, message_last, input ready);
  modport sink   (input valid, data_byte, status, run_last, message_last, output ready);
endinterface

// ===== rtl/core/hsd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hsd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  // Write and registered read; read data holds while idle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/hsd_ctrl.sv =====
// Block control: stores data bytes, folds syndrome and parity, judges the check byte.
// Depends on hsd_pkg, hsd_if and assert_macros.svh.
`include "assert_macros.svh"
module hsd_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  hsd_in_if.sink                        coded,
  input  logic                          emit_idle,
  output hsd_pkg::emit_cmd_t            cmd,
  output logic                          wr_en,
  output logic [hsd_pkg::CountW-1:0]    wr_addr,
  output logic [hsd_pkg::ByteW-1:0]     wr_data
);

  logic [hsd_pkg::CountW-1:0] byte_count;
  logic [hsd_pkg::SynW-1:0]   syndrome_acc;
  logic                       data_parity;
  logic                       dropping;

  logic                       accept;
  logic                       is_data;
  logic [hsd_pkg::SynW-1:0]   contrib;
  logic [hsd_pkg::SynW-1:0]   syn;
  logic                       par;
  logic                       fix;
  logic [hsd_pkg::LocW-1:0]   loc;

  assign coded.ready = emit_idle;
  assign accept      = coded.valid && coded.ready;
  assign is_data     = !dropping && !coded.message_end &&
                       (byte_count < hsd_pkg::CountW'(hsd_pkg::DataMax));

  // Fold the syndrome contribution of the incoming byte
  always_comb begin
    contrib = '0;
    for (int k = 0; k < hsd_pkg::ByteW; k++) begin
      if (coded.code_byte[k])
        contrib = contrib ^ hsd_pkg::bit_pos({byte_count, 3'(k)});
    end
  end

  // Apply the check byte and locate a single data-bit error
  always_comb begin
    syn = syndrome_acc ^ coded.code_byte[hsd_pkg::SynW-1:0];
    par = data_parity ^ (^coded.code_byte);
    fix = (syn != '0) && ((syn & (syn - hsd_pkg::SynW'(1))) != '0);
    loc = syn - hsd_pkg::LocW'(hsd_pkg::floor_log2(syn)) - hsd_pkg::LocW'(2);
  end

  // Command for the emitter
  always_comb begin
    cmd.start    = accept && !is_data && !dropping;
    cmd.n        = byte_count;
    cmd.msg_end  = coded.message_end;
    cmd.fix_idx  = loc[hsd_pkg::LocW-1:3];
    cmd.fix_en   = fix && (loc[hsd_pkg::LocW-1:3] < byte_count);
    cmd.fix_mask = hsd_pkg::ByteW'(1) << loc[2:0];
    if (byte_count == '0)
      cmd.status = hsd_pkg::STATUS_TRUNC;
    else if ((syn != '0) && !par)
      cmd.status = hsd_pkg::STATUS_DOUBLE;
    else
      cmd.status = hsd_pkg::STATUS_OK;
  end

  assign wr_en   = accept && is_data;
  assign wr_addr = byte_count;
  assign wr_data = coded.code_byte;

  // Hold block state; clear at block end, drop the rest after a double error
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      syndrome_acc <= '0;
      data_parity  <= 1'b0;
      dropping     <= 1'b0;
    end else if (accept) begin
      if (dropping) begin
        if (coded.message_end) begin
          dropping     <= 1'b0;
          byte_count   <= '0;
          syndrome_acc <= '0;
          data_parity  <= 1'b0;
        end
      end else if (is_data) begin
        byte_count   <= byte_count + hsd_pkg::CountW'(1);
        syndrome_acc <= syndrome_acc ^ contrib;
        data_parity  <= data_parity ^ (^coded.code_byte);
      end else begin
        byte_count   <= '0;
        syndrome_acc <= '0;
        data_parity  <= 1'b0;
        if ((cmd.status == hsd_pkg::STATUS_DOUBLE) && !coded.message_end)
          dropping <= 1'b1;
      end
    end
  end

  `HSD_ASSERT_IMP(a_wr_in_range, clk, rst, wr_en, byte_count < hsd_pkg::CountW'(hsd_pkg::DataMax))
  `HSD_ASSERT_NXT(a_drop_after_double, clk, rst, cmd.start && (cmd.status == hsd_pkg::STATUS_DOUBLE) && !coded.message_end, dropping && (byte_count == '0))

endmodule

// ===== rtl/core/hsd_emit.sv =====
// Emitter: reads the block buffer, applies the correction and drives the output register.
// Depends on hsd_pkg, hsd_if and assert_macros.svh.
`include "assert_macros.svh"
module hsd_emit (
  input  logic                       clk,
  input  logic                       rst,
  input  hsd_pkg::emit_cmd_t         cmd,
  output logic                       idle,
  output logic                       rd_en,
  output logic [hsd_pkg::CountW-1:0] rd_addr,
  input  logic [hsd_pkg::ByteW-1:0]  rd_data,
  hsd_out_if.source                  decoded
);

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t                     state;
  logic [hsd_pkg::CountW-1:0] emit_n;
  logic [hsd_pkg::CountW-1:0] rd_idx;
  logic [hsd_pkg::CountW-1:0] pend_idx;
  logic                       rd_pending;
  logic                       fix_en;
  logic [hsd_pkg::CountW-1:0] fix_idx;
  logic [hsd_pkg::ByteW-1:0]  fix_mask;
  logic                       msg_end;

  logic                       out_valid;
  logic [hsd_pkg::ByteW-1:0]  out_data;
  hsd_pkg::status_t           out_status;
  logic                       out_run_last;
  logic                       out_msg_last;

  logic                       out_free;
  logic                       load;
  logic                       err_load;
  logic                       issue_done;
  logic                       out_err;
  logic                       err_shape_ok;

  assign decoded.valid        = out_valid;
  assign decoded.data_byte    = out_data;
  assign decoded.status       = out_status;
  assign decoded.run_last     = out_run_last;
  assign decoded.message_last = out_msg_last;

  // The output register frees when empty or when its transfer completes
  assign out_free   = !out_valid || decoded.ready;
  assign load       = rd_pending && out_free;
  assign err_load   = cmd.start && (cmd.status != hsd_pkg::STATUS_OK);
  assign issue_done = (rd_idx == emit_n);
  assign rd_en      = (state == S_RUN) && !issue_done && (!rd_pending || load);
  assign rd_addr    = rd_idx;
  assign idle       = (state == S_IDLE) && out_free;

  // Sequence the run and hold the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.start && (cmd.status == hsd_pkg::STATUS_OK)) begin
            state    <= S_RUN;
            emit_n   <= cmd.n;
            rd_idx   <= '0;
            fix_en   <= cmd.fix_en;
            fix_idx  <= cmd.fix_idx;
            fix_mask <= cmd.fix_mask;
            msg_end  <= cmd.msg_end;
          end
        end
        S_RUN: begin
          if (rd_en) rd_idx <= rd_idx + hsd_pkg::CountW'(1);
          if (issue_done && (!rd_pending || load)) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      // Track the read in flight
      if (rd_en) begin
        rd_pending <= 1'b1;
        pend_idx   <= rd_idx;
      end else if (load) begin
        rd_pending <= 1'b0;
      end

      // Load corrected read data or an error result, else free on transfer
      if (load) begin
        out_valid    <= 1'b1;
        out_data     <= rd_data ^ ((fix_en && (pend_idx == fix_idx)) ? fix_mask : '0);
        out_status   <= hsd_pkg::STATUS_OK;
        out_run_last <= (pend_idx == emit_n - hsd_pkg::CountW'(1));
        out_msg_last <= msg_end;
      end else if (err_load) begin
        out_valid    <= 1'b1;
        out_data     <= '0;
        out_status   <= cmd.status;
        out_run_last <= 1'b1;
        out_msg_last <= 1'b1;
      end else if (out_valid && decoded.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_err      = out_valid && (out_status != hsd_pkg::STATUS_OK);
  assign err_shape_ok = (out_data == '0) && out_run_last && out_msg_last;

  `HSD_ASSERT_IMP(a_read_in_run, clk, rst, rd_en, rd_idx < emit_n)
  `HSD_ASSERT_IMP(a_last_drains, clk, rst, out_valid && out_run_last, !rd_pending)
  `HSD_ASSERT_IMP(a_error_shape, clk, rst, out_err, err_shape_ok)

endmodule

// ===== rtl/core/hamming_secded_block_decoder.sv =====
// Top level of the SECDED (128,120) block decoder.
// Depends on hsd_pkg, hsd_if, hsd_ram, hsd_ctrl and hsd_emit.
//
// Usage:
//   coded   - input stream of bytes; a block is up to 15 data bytes and one
//             check byte, message_end marks the final byte of a message.
//   decoded - output stream of corrected data bytes with status, run_last
//             (last byte of a block run) and message_last.
// Data bytes are taken one per cycle while the emitter is idle and stored in a
// 15-entry RAM while the syndrome and parity fold in. On the check byte the block
// is judged: an error result (double error or lone check byte) is loaded into the
// output register in the next cycle; a good block is read back from the RAM
// through its registered read port into the output register, and its bytes
// follow at one byte per cycle while decoded does not stall. Read-out is set by
// the single RAM read port; input is held off while the block is read out.
// A stall on decoded freezes the read-out; the output register holds its
// byte until the transfer completes.
// Reset clears the block state and the drop flag; the buffer RAM is not
// cleared, as only entries written in the current block are ever read.
module hamming_secded_block_decoder (
  input  logic      clk,
  input  logic      rst,
  hsd_in_if.sink    coded,
  hsd_out_if.source decoded
);

  hsd_pkg::emit_cmd_t         cmd;
  logic                       emit_idle;
  logic                       wr_en;
  logic [hsd_pkg::CountW-1:0] wr_addr;
  logic [hsd_pkg::ByteW-1:0]  wr_data;
  logic                       rd_en;
  logic [hsd_pkg::CountW-1:0] rd_addr;
  logic [hsd_pkg::ByteW-1:0]  rd_data;

  hsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .coded     (coded),
    .emit_idle (emit_idle),
    .cmd       (cmd),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  hsd_ram #(
    .Width (hsd_pkg::ByteW),
    .Depth (hsd_pkg::DataMax)
  ) u_buffer (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hsd_emit u_emit (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .idle    (emit_idle),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .decoded (decoded)
  );

endmodule

// ===== tb/decode_checker.sv =====
`timescale 1ns / 100ps
// Checker for the SECDED block decoder: predicts the decoded bytes from the coded
// transfers and compares every decoded transfer with the oldest prediction.
// Depends on hsd_pkg (status codes, sizes) and hsd_if (stream interfaces).
module decode_checker (
  input  logic        clk,
  input  logic        rst,
  hsd_in_if           coded,
  hsd_out_if          decoded,
  output int unsigned fail_count,
  output int unsigned pending
);
  import hsd_pkg::*;

  localparam int unsigned ReportMax = 10;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    status_t          status;
    logic             run_last;
    logic             message_last;
  } decoded_t;

  decoded_t          expected_bytes[$];
  logic [ByteW-1:0]  held_bytes [DataMax];
  logic [CountW-1:0] held_count;
  logic [SynW-1:0]   syn_fold;
  logic              par_fold;
  logic              skipping;
  int unsigned       mismatches = 0;

  // Hamming position of data bit j: count up from 3, stepping over 4, 8, 16, 32, 64
  function automatic logic [SynW-1:0] code_position(input int unsigned j);
    int unsigned p;
    p = j + 3;
    for (int unsigned pw = FirstSkip; pw <= 64; pw = pw << 1)
      if (p >= pw) p++;
    return SynW'(p);
  endfunction

  task automatic clear_block();
    held_count = '0;
    syn_fold   = '0;
    par_fold   = 1'b0;
  endtask

  // Fold one coded byte into the block state and queue whatever it releases
  task automatic decode_byte(input logic [ByteW-1:0] code, input logic closes);
    logic [SynW-1:0] syn;
    int unsigned     msb, loc, n;
    if (skipping) begin
      if (closes) begin
        skipping = 1'b0;
        clear_block();
      end
      return;
    end
    // store a data byte
    if (!closes && held_count < DataMax) begin
      held_bytes[held_count] = code;
      for (int k = 0; k < ByteW; k++)
        if (code[k]) syn_fold ^= code_position(ByteW * held_count + k);
      par_fold ^= ^code;
      held_count++;
      return;
    end
    // check byte with nothing held: truncated block
    if (held_count == 0) begin
      clear_block();
      expected_bytes.push_back('{8'h00, STATUS_TRUNC, 1'b1, 1'b1});
      return;
    end
    syn = syn_fold ^ code[SynW-1:0];
    if (syn != '0) begin
      // even overall parity with a nonzero syndrome: double error
      if ((par_fold ^ (^code)) == 1'b0) begin
        clear_block();
        if (!closes) skipping = 1'b1;
        expected_bytes.push_back('{8'h00, STATUS_DOUBLE, 1'b1, 1'b1});
        return;
      end
      // not a power of two: flip the named data bit if it is held
      if ((syn & (syn - 1'b1)) != '0) begin
        msb = 0;
        for (int i = 1; i < SynW; i++)
          if (syn[i]) msb = i;
        loc = syn - msb - 2;
        if (loc / ByteW < held_count) held_bytes[loc / ByteW][loc % ByteW] ^= 1'b1;
      end
    end
    n = held_count;
    for (int i = 0; i < n; i++)
      expected_bytes.push_back('{held_bytes[i], STATUS_OK, i == n - 1, closes});
    clear_block();
  endtask

  // Predict on coded transfers, compare on decoded transfers
  always @(posedge clk) begin : watch
    decoded_t got, want;
    if (rst) begin
      expected_bytes.delete();
      clear_block();
      skipping = 1'b0;
    end else begin
      if (coded.valid && coded.ready) decode_byte(coded.code_byte, coded.message_end);
      if (decoded.valid && decoded.ready) begin
        got = '{decoded.data_byte, decoded.status, decoded.run_last, decoded.message_last};
        if (expected_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportMax)
            $display("%0t: unexpected transfer: data %02h status %0d run_last %0b msg_last %0b",
                     $realtime, got.data_byte, got.status, got.run_last, got.message_last);
        end else begin
          want = expected_bytes.pop_front();
          if (got.data_byte !== want.data_byte || got.status !== want.status ||
              got.run_last !== want.run_last || got.message_last !== want.message_last) begin
            mismatches++;
            if (mismatches <= ReportMax)
              $display("%0t: mismatch: expected data %02h status %0d run_last %0b msg_last %0b, got data %02h status %0d run_last %0b msg_last %0b",
                       $realtime, want.data_byte, want.status, want.run_last, want.message_last,
                       got.data_byte, got.status, got.run_last, got.message_last);
          end
        end
      end
    end
    fail_count <= mismatches;
    pending    <= expected_bytes.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the SECDED block decoder testbench: clock, reset, coded byte stimulus and
// decoded-side flow control. Uses hsd_pkg, hsd_if, the decoder and decode_checker.
module tb_top;
  import hsd_pkg::*;

  localparam int unsigned RandomItems  = 400;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned DrainLimit   = 20000;
  localparam int unsigned SettleCycles = 40;

  typedef enum int {
    BLK_CLEAN, BLK_DATA_FLIP, BLK_CHECK_FLIP, BLK_DOUBLE, BLK_BEYOND, BLK_WILD
  } flaw_t;

  logic clk;
  logic rst;
  hsd_in_if  coded ();
  hsd_out_if decoded ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned hold_asks     = 0;
  int unsigned items_sent    = 0;

  logic [ByteW-1:0] blk [DataMax];
  logic [SynW-1:0]  position_of [DataMax * ByteW];

  hamming_secded_block_decoder u_dut (
    .clk     (clk),
    .rst     (rst),
    .coded   (coded),
    .decoded (decoded)
  );

  decode_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .coded      (coded),
    .decoded    (decoded),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard limit on the run
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Decoded side: random stalls, plus long hold-offs on request
  initial begin : sink_side
    int unsigned hold_seen, hold_left;
    hold_seen = 0;
    hold_left = 0;
    decoded.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        decoded.ready <= 1'b0;
      end else begin
        decoded.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Offer one coded byte, idling first at random, and hold it until the transfer
  task automatic offer(input logic [ByteW-1:0] code, input logic closes);
    while ($urandom_range(99) < src_idle_pct) begin
      coded.valid <= 1'b0;
      @(negedge clk);
    end
    coded.valid       <= 1'b1;
    coded.code_byte   <= code;
    coded.message_end <= closes;
    @(posedge clk);
    while (!coded.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Encode blk[0..n-1], apply the flaw, send the data bytes and the check byte
  task automatic send_block(input int unsigned n, input flaw_t flaw, input logic closes);
    logic [ByteW-1:0] tx [DataMax];
    logic [SynW-1:0]  syn;
    logic [ByteW-1:0] chk;
    int unsigned      a_bit, b_bit, j;
    syn = '0;
    for (int i = 0; i < n; i++) begin
      tx[i] = blk[i];
      for (int k = 0; k < ByteW; k++)
        if (blk[i][k]) syn ^= position_of[ByteW * i + k];
    end
    // top check bit makes the whole block parity even
    chk = {1'b0, syn};
    chk[7] = ^syn;
    for (int i = 0; i < n; i++) chk[7] ^= ^blk[i];
    case (flaw)
      BLK_DATA_FLIP: begin
        a_bit = $urandom_range(ByteW * n - 1);
        tx[a_bit / ByteW][a_bit % ByteW] ^= 1'b1;
      end
      BLK_CHECK_FLIP: chk[$urandom_range(7)] ^= 1'b1;
      BLK_DOUBLE: begin
        a_bit = $urandom_range(ByteW * n + 7);
        b_bit = (a_bit + 1 + $urandom_range(ByteW * n + 6)) % (ByteW * n + 8);
        for (int t = 0; t < 2; t++) begin
          j = (t == 0) ? a_bit : b_bit;
          if (j < ByteW * n) tx[j / ByteW][j % ByteW] ^= 1'b1;
          else chk[j - ByteW * n] ^= 1'b1;
        end
      end
      BLK_BEYOND: begin
        // syndrome names a bit past the held bytes, parity left odd
        if (n < DataMax) begin
          j = $urandom_range(DataMax * ByteW - 1, ByteW * n);
          chk[SynW-1:0] ^= position_of[j];
          chk[7] ^= ~(^position_of[j]);
        end
      end
      BLK_WILD: chk = ByteW'($urandom);
      default: ;
    endcase
    for (int i = 0; i < n; i++) offer(tx[i], 1'b0);
    offer(chk, closes);
  endtask

  // Well-formed message: full blocks, then a closing block of random size
  task automatic send_message();
    int unsigned nblocks, r, n;
    logic        closing;
    flaw_t       flaw;
    r = $urandom_range(99);
    nblocks = (r < 70) ? 1 : (r < 90) ? 2 : 3;
    for (int m = 0; m < nblocks; m++) begin
      closing = (m == nblocks - 1);
      if (!closing) n = DataMax;
      else if ($urandom_range(99) < 80) n = $urandom_range(6, 1);
      else n = $urandom_range(DataMax, 7);
      for (int i = 0; i < n; i++) blk[i] = ByteW'($urandom);
      r = $urandom_range(99);
      flaw = (r < 55) ? BLK_CLEAN : (r < 70) ? BLK_DATA_FLIP : (r < 80) ? BLK_CHECK_FLIP :
             (r < 90) ? BLK_DOUBLE : (r < 95) ? BLK_BEYOND : BLK_WILD;
      send_block(n, flaw, closing);
    end
  endtask

  initial begin : stimulus
    int unsigned p, base, done, waited, r;
    logic        hold_early, hold_late;
    rst               = 1'b1;
    coded.valid       = 1'b0;
    coded.code_byte   = '0;
    coded.message_end = 1'b0;
    hold_early        = 1'b0;
    hold_late         = 1'b0;

    // Hamming positions: walk upward from 3 and step over the powers of two
    p = 3;
    for (int j = 0; j < DataMax * ByteW; j++) begin
      while ((p & (p - 1)) == 0) p++;
      position_of[j] = SynW'(p);
      p++;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    src_idle_pct  = 31;
    sink_idle_pct = 58;

    // Directed: lone check byte, one-byte blocks: clean, data, check, beyond flaw
    offer(8'hff, 1'b1);
    blk[0] = 8'hff;
    send_block(1, BLK_CLEAN, 1'b1);
    blk[0] = 8'h00;
    send_block(1, BLK_DATA_FLIP, 1'b1);
    blk[0] = 8'ha5;
    send_block(1, BLK_CHECK_FLIP, 1'b1);
    blk[0] = 8'h5a;
    send_block(1, BLK_BEYOND, 1'b1);
    // full block with a double error mid-message, then the dropped tail
    for (int i = 0; i < DataMax; i++) blk[i] = i[0] ? 8'hff : 8'h00;
    send_block(DataMax, BLK_DOUBLE, 1'b0);
    offer(8'h3c, 1'b0);
    offer(8'hc3, 1'b1);

    // Random: three idling phases, two long hold-offs on the decoded side
    base = items_sent;
    while (items_sent - base < RandomItems) begin
      done = items_sent - base;
      if (done < RandomItems / 3) begin
        src_idle_pct  = 31;
        sink_idle_pct = 58;
      end else if (done < 2 * RandomItems / 3) begin
        src_idle_pct  = 58;
        sink_idle_pct = 31;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      if (!hold_early && done >= 60) begin
        hold_asks++;
        hold_early = 1'b1;
      end
      if (!hold_late && done >= 300) begin
        hold_asks++;
        hold_late = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 80) begin
        send_message();
      end else if (r < 88) begin
        // message that stops right after a full block: lone check byte follows
        for (int i = 0; i < DataMax; i++) blk[i] = ByteW'($urandom);
        send_block(DataMax, BLK_CLEAN, 1'b0);
        offer(ByteW'($urandom), 1'b1);
      end else begin
        repeat ($urandom_range(8, 1)) offer(ByteW'($urandom), $urandom_range(99) < 25);
      end
    end
    coded.valid <= 1'b0;

    // Drain what is still expected, then let any stray transfer show up
    waited = 0;
    while (pending != 0 && waited < DrainLimit) begin
      @(negedge clk);
      waited++;
    end
    repeat (SettleCycles) @(negedge clk);
    if (pending == 0 && fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/hsd_pkg.sv
rtl/core/hsd_if.sv
rtl/core/hsd_ram.sv
rtl/core/hsd_ctrl.sv
rtl/core/hsd_emit.sv
rtl/core/hamming_secded_block_decoder.sv
tb/decode_checker.sv
tb/tb_top.sv
